@@ rtl/tgd_pkg.sv @@
// ---------------------------------------------------------------------------
// tgd_pkg
// shared types and constants of the turning grille decipher block
// ---------------------------------------------------------------------------
`default_nettype none

package tgd_pkg;

    localparam int SIDE_W = 4;
    localparam int SYM_W  = 8;

    typedef enum logic [1:0]
    {
        KIND_PLAIN  = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    typedef struct packed
    {
        logic              wr;
        logic [SIDE_W-1:0] n;
    } cfg_t;

    typedef struct packed
    {
        kind_t            kind;
        logic [SYM_W-1:0] plain_symbol;
        logic             last;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/tgd_cfg.sv @@
// ---------------------------------------------------------------------------
// tgd_cfg
// apb register file: grille side register and effective side clamp
// ---------------------------------------------------------------------------
`default_nettype none

module tgd_cfg #(
    parameter int MAX_SIDE = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output tgd_pkg::cfg_t    cfg
);
    import tgd_pkg::*;

    localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(4);
    localparam logic [SIDE_W-1:0] SIDE_MAX   = SIDE_W'(MAX_SIDE);

    logic [SIDE_W-1:0] side_reg;
    logic              side_sel;
    logic              side_wr;

    assign side_sel = (paddr[2] == 1'b0);
    assign side_wr  = psel & penable & pwrite & side_sel;
    assign pready   = 1'b1;
    assign prdata   = side_sel ? 32'(side_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= SIDE_RESET;
        end
        else if (side_wr)
        begin
            side_reg <= pwdata[SIDE_W-1:0];
        end
    end

    always_comb
    begin
        cfg.wr = side_wr;
        priority if (side_reg == '0)
        begin
            cfg.n = SIDE_W'(1);
        end
        else if (side_reg > SIDE_MAX)
        begin
            cfg.n = SIDE_MAX;
        end
        else
        begin
            cfg.n = side_reg;
        end
    end

endmodule

`default_nettype wire

@@ rtl/tgd_addr.sv @@
// ---------------------------------------------------------------------------
// tgd_addr
// address unit: row-major index of a board cell seen through a turn
// ---------------------------------------------------------------------------
`default_nettype none

module tgd_addr #(
    parameter int CW = 3,
    parameter int NW = 4,
    parameter int AW = 6
) (
    input  wire logic [NW-1:0] n,
    input  wire logic [1:0]    rot,
    input  wire logic [CW-1:0] row,
    input  wire logic [CW-1:0] col,
    output logic      [AW-1:0] addr
);
    logic [NW-1:0]    n_m1;
    logic [CW-1:0]    last_idx;
    logic [CW-1:0]    src_row;
    logic [CW-1:0]    src_col;
    logic [CW+NW-1:0] prod;
    logic [CW+NW:0]   sum;

    assign n_m1     = n - NW'(1);
    assign last_idx = n_m1[CW-1:0];

    // source cell of the original mask after rot clockwise quarter turns
    always_comb
    begin
        unique case (rot)
            2'd0:
            begin
                src_row = row;
                src_col = col;
            end
            2'd1:
            begin
                src_row = last_idx - col;
                src_col = row;
            end
            2'd2:
            begin
                src_row = last_idx - row;
                src_col = last_idx - col;
            end
            2'd3:
            begin
                src_row = col;
                src_col = last_idx - row;
            end
        endcase
    end

    assign prod = (CW+NW)'(src_row) * (CW+NW)'(n);
    assign sum  = (CW+NW+1)'(prod) + (CW+NW+1)'(src_col);
    assign addr = sum[AW-1:0];

endmodule

`default_nettype wire

@@ rtl/tgd_seq.sv @@
// ---------------------------------------------------------------------------
// tgd_seq
// sequencer: grille and block storage, order table build, plaintext readout
// ---------------------------------------------------------------------------
`default_nettype none

module tgd_seq #(
    parameter int MAX_SIDE = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  tgd_pkg::cfg_t              cfg,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  in_action,
    input  wire logic                  in_hole,
    input  wire logic [tgd_pkg::SYM_W-1:0] in_symbol,
    input  wire logic                  res_full,
    output logic                       res_push,
    output tgd_pkg::result_t           res
);
    import tgd_pkg::*;

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_SIDE);
    localparam int NW    = $clog2(MAX_SIDE + 1);
    localparam int CNTW  = $clog2(DEPTH + 1);
    localparam logic [1:0] LAST_TURN = 2'd3;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_B_RD,
        S_B_APPLY,
        S_GRILLE_OUT,
        S_E_ORD,
        S_E_BUF,
        S_E_OUT
    } state_t;

    typedef enum logic [1:0]
    {
        G_LOADING,
        G_ACCEPTED,
        G_REJECTED
    } gstate_t;

    state_t            state_reg;
    gstate_t           gstate_reg;
    kind_t             gkind_reg;
    logic [CNTW-1:0]   cnt_reg;
    logic [CNTW-1:0]   holes_reg;
    logic [1:0]        rot_reg;
    logic [CW-1:0]     row_reg;
    logic [CW-1:0]     col_reg;
    logic [AW-1:0]     pos_reg;
    logic [AW-1:0]     k_reg;
    logic              dup_reg;
    logic [DEPTH-1:0]  seen_reg;
    logic [AW-1:0]     jj_reg;

    logic              mask_mem [DEPTH];
    logic [AW-1:0]     order_mem [DEPTH];
    logic [SYM_W-1:0]  buf_mem [DEPTH];
    logic              mask_q;
    logic [AW-1:0]     order_q;
    logic [SYM_W-1:0]  buf_q;

    logic [NW-1:0]     n;
    logic [NW-1:0]     n_m1;
    logic [CW-1:0]     last_idx;
    logic [2*NW-1:0]   n_sq;
    logic [CNTW-1:0]   cells;
    logic              accept;
    logic              cnt_room;
    logic [CNTW-1:0]   cnt_after;
    logic              block_full;
    logic [CNTW-1:0]   holes_base;
    logic [CNTW-1:0]   holes_new;
    logic              quarter_ok;
    logic              load_cell;
    logic              load_sym;
    logic              mask_we;
    logic              buf_we;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     src_addr;
    logic [CNTW-1:0]   pos_plus;
    logic [CNTW-1:0]   jj_plus;
    logic              pos_last;
    logic              jj_last;
    logic              dup_now;
    logic              order_we;

    assign n        = cfg.n[NW-1:0];
    assign n_m1     = n - NW'(1);
    assign last_idx = n_m1[CW-1:0];
    assign n_sq     = n * n;
    assign cells    = CNTW'(n_sq);

    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid & in_ready;
    assign load_cell  = accept & ~in_action & (gstate_reg == G_LOADING);
    assign load_sym   = accept & in_action & (gstate_reg == G_ACCEPTED);
    assign cnt_room   = (cnt_reg < cells);
    assign cnt_after  = cnt_room ? CNTW'(cnt_reg + CNTW'(1)) : cnt_reg;
    assign block_full = (cnt_after >= cells);
    assign holes_base = (cnt_reg == '0) ? '0 : holes_reg;
    assign holes_new  = cnt_room ? CNTW'(holes_base + CNTW'(in_hole)) : holes_base;
    assign quarter_ok = ({holes_new, 2'b00} == (CNTW+2)'(cells));
    assign mask_we    = load_cell & cnt_room;
    assign buf_we     = load_sym & cnt_room;
    assign wr_addr    = cnt_reg[AW-1:0];

    assign pos_plus = CNTW'(pos_reg) + CNTW'(1);
    assign jj_plus  = CNTW'(jj_reg) + CNTW'(1);
    assign pos_last = (pos_plus == cells);
    assign jj_last  = (jj_plus == cells);
    assign dup_now  = dup_reg | (mask_q & seen_reg[pos_reg]);
    assign order_we = (state_reg == S_B_APPLY) & mask_q;

    tgd_addr #(
        .CW (CW),
        .NW (NW),
        .AW (AW)
    ) u_addr (
        .n    (n),
        .rot  (rot_reg),
        .row  (row_reg),
        .col  (col_reg),
        .addr (src_addr)
    );

    always_ff @(posedge clk)
    begin
        if (mask_we)
        begin
            mask_mem[wr_addr] <= in_hole;
        end
        if (state_reg == S_B_RD)
        begin
            mask_q <= mask_mem[src_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (order_we)
        begin
            order_mem[pos_reg] <= k_reg;
        end
        if (state_reg == S_E_ORD)
        begin
            order_q <= order_mem[jj_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_mem[wr_addr] <= in_symbol;
        end
        if (state_reg == S_E_BUF)
        begin
            buf_q <= buf_mem[order_q];
        end
    end

    assign res_push = ((state_reg == S_GRILLE_OUT) | (state_reg == S_E_OUT)) & ~res_full;

    always_comb
    begin
        if (state_reg == S_E_OUT)
        begin
            res.kind         = KIND_PLAIN;
            res.plain_symbol = buf_q;
            res.last         = jj_last;
        end
        else
        begin
            res.kind         = gkind_reg;
            res.plain_symbol = '0;
            res.last         = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            gstate_reg <= G_LOADING;
            gkind_reg  <= KIND_REJECT;
            cnt_reg    <= '0;
            holes_reg  <= '0;
            rot_reg    <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
            pos_reg    <= '0;
            k_reg      <= '0;
            dup_reg    <= 1'b0;
            seen_reg   <= '0;
            jj_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    priority if (cfg.wr)
                    begin
                        cnt_reg    <= '0;
                        gstate_reg <= G_LOADING;
                    end
                    else if (load_cell)
                    begin
                        if (!block_full)
                        begin
                            cnt_reg   <= cnt_after;
                            holes_reg <= holes_new;
                        end
                        else
                        begin
                            cnt_reg <= '0;
                            if (quarter_ok)
                            begin
                                rot_reg   <= '0;
                                row_reg   <= '0;
                                col_reg   <= '0;
                                pos_reg   <= '0;
                                k_reg     <= '0;
                                dup_reg   <= 1'b0;
                                seen_reg  <= '0;
                                state_reg <= S_B_RD;
                            end
                            else
                            begin
                                gstate_reg <= G_REJECTED;
                                gkind_reg  <= KIND_REJECT;
                                state_reg  <= S_GRILLE_OUT;
                            end
                        end
                    end
                    else if (load_sym)
                    begin
                        if (!block_full)
                        begin
                            cnt_reg <= cnt_after;
                        end
                        else
                        begin
                            cnt_reg   <= '0;
                            jj_reg    <= '0;
                            state_reg <= S_E_ORD;
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg;
                    end
                end
                S_B_RD:
                begin
                    state_reg <= S_B_APPLY;
                end
                S_B_APPLY:
                begin
                    if (mask_q)
                    begin
                        k_reg             <= k_reg + AW'(1);
                        dup_reg           <= dup_now;
                        seen_reg[pos_reg] <= 1'b1;
                    end
                    if (pos_last && (rot_reg == LAST_TURN))
                    begin
                        gstate_reg <= dup_now ? G_REJECTED : G_ACCEPTED;
                        gkind_reg  <= dup_now ? KIND_REJECT : KIND_ACCEPT;
                        state_reg  <= S_GRILLE_OUT;
                    end
                    else
                    begin
                        pos_reg <= pos_last ? '0 : pos_plus[AW-1:0];
                        if (col_reg == last_idx)
                        begin
                            col_reg <= '0;
                            if (row_reg == last_idx)
                            begin
                                row_reg <= '0;
                                rot_reg <= rot_reg + 2'd1;
                            end
                            else
                            begin
                                row_reg <= row_reg + CW'(1);
                            end
                        end
                        else
                        begin
                            col_reg <= col_reg + CW'(1);
                        end
                        state_reg <= S_B_RD;
                    end
                end
                S_GRILLE_OUT:
                begin
                    if (!res_full)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_E_ORD:
                begin
                    state_reg <= S_E_BUF;
                end
                S_E_BUF:
                begin
                    state_reg <= S_E_OUT;
                end
                S_E_OUT:
                begin
                    if (!res_full)
                    begin
                        if (jj_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            jj_reg    <= jj_plus[AW-1:0];
                            state_reg <= S_E_ORD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/turning_grille_decipher_top.sv @@
// ---------------------------------------------------------------------------
// turning_grille_decipher_top
// turning grille decipher: loads a grille, builds its read order, then
// deciphers ciphertext in blocks of side squared symbols
//
//   channel   dir  handshake          payload
//   s_*       in   tvalid / tready    tuser action, tdata hole + symbol
//   m_*       out  tvalid / tready    tuser kind, tdata plain_symbol, tlast
//   apb       in   psel / penable     side register at byte 0
//
// grille cells and ciphertext symbols are taken one per cycle while
// collecting; the request that completes a grille with a quarter of its
// cells as holes starts an order build (mask read, then apply, per cell
// for each of four turns) on the address unit, and the request that
// completes a block starts a readout (order read, buffer read, output)
// of each plaintext symbol. s_tready stays low during build and readout;
// a stalled m_tready holds the output register and the sequencer. reset
// restores side 4 and the grille loading state; no memory clearing is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module turning_grille_decipher_top #(
    parameter int MAX_SIDE = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // hole[0], symbol[8:1], zero fill
    input  wire logic        s_tuser,   // action[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata,   // plain_symbol[7:0]
    output logic      [1:0]  m_tuser,   // kind[1:0]
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import tgd_pkg::*;

    cfg_t    cfg;
    result_t res;
    result_t out_reg;
    logic    out_valid_reg;
    logic    res_push;

    tgd_cfg #(
        .MAX_SIDE (MAX_SIDE)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tgd_seq #(
        .MAX_SIDE (MAX_SIDE)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tuser),
        .in_hole   (s_tdata[0]),
        .in_symbol (s_tdata[8:1]),
        .res_full  (out_valid_reg),
        .res_push  (res_push),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else if (res_push)
        begin
            out_valid_reg <= 1'b1;
            out_reg       <= res;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.plain_symbol;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

endmodule

`default_nettype wire
